>>> sv/segment_table_lookup_assert.svh
// Assertion macros used by the checker of the segment table lookup.
`ifndef SEGMENT_TABLE_LOOKUP_ASSERT_SVH
`define SEGMENT_TABLE_LOOKUP_ASSERT_SVH

// Same-cycle implication, sampled on aclk and off while reset is held.
`define STL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and off while reset is held.
`define STL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/stl_pkg.sv
// Package with the field layout and constants of the segment table lookup.
`timescale 1ns / 1ps
`default_nettype none
package stl_pkg;

    localparam int CNT_W       = 7;
    localparam int IN_DATA_W   = 168;
    localparam int OUT_DATA_W  = 128;
    localparam int ENTRY_W     = 96;

    localparam logic [63:0] MASK_256MB = 64'hFFFF_FFFF_F000_0000;
    localparam logic [63:0] MASK_1TB   = 64'hFFFF_FF00_0000_0000;

    localparam int VALID_BIT = 27;

    typedef enum logic [1:0] {
        SIZE_256MB = 2'b00,
        SIZE_1TB   = 2'b01,
        SIZE_RES_A = 2'b10,
        SIZE_RES_B = 2'b11
    } seg_size_t;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } stl_op_t;

endpackage
`default_nettype wire

>>> sv/segment_table_lookup.sv
// Segment lookaside table: entry store and sequential first-match lookup.
//
// Usage. Items arrive on the s_ channel: s_tuser selects a write (0) or a
// lookup (1). A write stores a 96-bit entry at entry_index; a lookup scans
// slots 0 up to entries_in_use-1 (capped at TABLE_ENTRIES) in order and
// returns the first valid entry whose masked segment bits match the address.
// Every item gives exactly one result item on the m_ channel; m_tuser is the
// found flag, and all result fields are zero when nothing matched or for a
// write. entries_in_use is set through cfg_we and cfg_wdata; the user must
// write it only while idle, since the block itself does not enforce this.
// Timing: an item is taken in the idle state only. A write, or a lookup
// with a zero count, goes straight to done; any other lookup reads the
// slots over the single memory read port, one a cycle, to a hit or the end.
// Reset clears the control state, the register and every entry's valid bit,
// so all slots read as empty at once. If the receiver stalls, the result
// waits in the output register; the next item is still taken and worked on,
// and it only waits once its own result is ready to go out.
`timescale 1ns / 1ps
`default_nettype none
module segment_table_lookup
    import stl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CNT_W-1:0]      cfg_wdata,      // entries_in_use
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // entry_index[5:0], entry_high[69:6], entry_low[101:70], address[165:102]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  s_tuser,        // operation
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // vsid[49:0], offset_mask[113:50], attributes[121:114]
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tuser         // found
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        entries_in_use_reg;
    logic [CNT_W-1:0]        limit_reg;
    logic [CNT_W-1:0]        issue_reg;
    logic [CNT_W-1:0]        rd_num_reg;
    logic                    rd_pend_reg;
    logic [63:0]             addr_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic                    res_found_reg;
    logic [49:0]             res_vsid_reg;
    logic [63:0]             res_mask_reg;
    logic [7:0]              res_attr_reg;

    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic                    m_tuser_reg;

    logic [ENTRY_W-1:0]      mem [TABLE_ENTRIES];
    logic [ENTRY_W-1:0]      rd_data_reg;
    logic                    rd_vld_reg;

    // Input field views.
    logic [5:0]              in_index;
    logic [63:0]             in_high;
    logic [31:0]             in_low;
    logic [63:0]             in_addr;
    logic                    accept;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_idx;
    logic [IDX_W-1:0]        rd_idx;
    logic [CNT_W-1:0]        limit_next;

    // Entry under test.
    logic [63:0]             row_high;
    logic [31:0]             row_low;
    seg_size_t               row_size;
    logic [63:0]             row_mask;
    logic                    row_hit;
    logic                    scan_end;

    assign in_index = s_tdata[5:0];
    assign in_high  = s_tdata[69:6];
    assign in_low   = s_tdata[101:70];
    assign in_addr  = s_tdata[165:102];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && (stl_op_t'(s_tuser) == OP_WRITE)
                      && ({1'b0, in_index} < CNT_W'(TABLE_ENTRIES));
    assign wr_idx   = in_index[IDX_W-1:0];
    assign rd_idx   = issue_reg[IDX_W-1:0];

    assign limit_next = (entries_in_use_reg > CNT_W'(TABLE_ENTRIES))
                        ? CNT_W'(TABLE_ENTRIES) : entries_in_use_reg;

    assign row_high = rd_data_reg[95:32];
    assign row_low  = rd_data_reg[31:0];
    assign row_size = seg_size_t'(row_high[26:25]);

    always_comb begin
        row_mask = MASK_256MB;
        row_hit  = 1'b0;
        case (row_size)
            SIZE_256MB: begin
                row_mask = MASK_256MB;
                row_hit  = ((addr_reg & MASK_256MB) == (row_high & MASK_256MB));
            end
            SIZE_1TB: begin
                row_mask = MASK_1TB;
                row_hit  = ((addr_reg & MASK_1TB) == (row_high & MASK_1TB));
            end
            default: begin
                row_hit = 1'b0;
            end
        endcase
        row_hit = row_hit && rd_vld_reg && row_high[VALID_BIT];
    end

    // The scan stops at the first hit or once the last slot has been examined.
    assign scan_end = rd_pend_reg && (row_hit || (rd_num_reg == limit_reg - CNT_W'(1)));

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= {in_high, in_low};
        end
        rd_data_reg <= mem[rd_idx];
        rd_vld_reg  <= valid_reg[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg          <= '0;
            entries_in_use_reg <= '0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (cfg_we) begin
                entries_in_use_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            rd_pend_reg  <= 1'b0;
            issue_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // In the done state the output register is always left holding an item.
            if (m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        res_found_reg <= 1'b0;
                        res_vsid_reg  <= '0;
                        res_mask_reg  <= '0;
                        res_attr_reg  <= '0;
                        addr_reg      <= in_addr;
                        limit_reg     <= limit_next;
                        issue_reg     <= '0;
                        rd_pend_reg   <= 1'b0;
                        if (stl_op_t'(s_tuser) == OP_LOOKUP && limit_next != '0) begin
                            state_reg <= S_SCAN;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    if (issue_reg < limit_reg) begin
                        issue_reg  <= issue_reg + CNT_W'(1);
                        rd_num_reg <= issue_reg;
                    end
                    rd_pend_reg <= (issue_reg < limit_reg) && !scan_end;
                    if (scan_end) begin
                        state_reg <= S_DONE;
                        if (row_hit) begin
                            res_found_reg <= 1'b1;
                            res_vsid_reg  <= {row_high[25:0], row_low[31:8]};
                            res_mask_reg  <= ~row_mask;
                            res_attr_reg  <= row_low[7:0];
                        end
                    end
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= res_found_reg;
                        m_tdata_reg  <= {6'd0, res_attr_reg, res_mask_reg, res_vsid_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

>>> sv/stl_checker.sv
// Port-level checker for the segment table lookup, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "segment_table_lookup_assert.svh"
module stl_checker
    import stl_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic                  m_tuser
);

    logic        m_stall;
    logic [63:0] res_mask;
    logic        mask_ok;

    assign m_stall  = m_tvalid && !m_tready;
    assign res_mask = m_tdata[113:50];
    assign mask_ok  = ((res_mask == 64'h0000_0000_0FFF_FFFF)
                       || (res_mask == 64'h0000_00FF_FFFF_FFFF))
                      && (m_tdata[127:122] == 6'd0);

    // A result item held back by the receiver must stay offered and unchanged.
    `STL_ASSERT_NEXT(a_hold_valid, m_stall, m_tvalid, "result item dropped")
    `STL_ASSERT_NEXT(a_hold_data, m_stall, $stable({m_tuser, m_tdata}), "result item changed")

    // Only one item is worked on at a time.
    `STL_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input taken while busy")

    // A miss or a write answers with every field cleared.
    `STL_ASSERT_IMPL(a_miss_zero, m_tvalid && !m_tuser, m_tdata == '0, "non-zero miss fields")

    // A hit carries one of the two legal offset masks and clean padding.
    `STL_ASSERT_IMPL(a_hit_mask, m_tvalid && m_tuser, mask_ok, "bad offset mask on a match")

endmodule

bind segment_table_lookup stl_checker u_stl_checker (.*);
`default_nettype wire

>>> tb/sv/tb_segment_table_lookup.sv
// Self-checking testbench of the segment table lookup: entry writes and lookups checked against a predictor.
`timescale 1ns / 1ps
module tb_segment_table_lookup;
    import stl_pkg::*;

    localparam int SLOTS      = 64;
    localparam int SIZE_LSB   = VALID_BIT - 2;
    localparam int CYCLE_CAP  = 600000;
    localparam int SETTLE     = 80;
    localparam int NUM_PHASES = 7;

    typedef struct packed {
        logic        found;
        logic [49:0] vsid;
        logic [63:0] offset_mask;
        logic [7:0]  attributes;
    } translation_t;

    typedef struct {
        stl_op_t     op;
        logic [5:0]  slot;
        logic [63:0] hi;
        logic [31:0] lo;
        logic [63:0] addr;
    } seg_item_t;

    class seg_scoreboard;
        logic [63:0]      seg_hi [SLOTS];
        logic [31:0]      seg_lo [SLOTS];
        logic [CNT_W-1:0] slots_searched;
        translation_t     pending [$];
        int               errors;

        function new();
            foreach (seg_hi[i]) begin
                seg_hi[i] = '0;
                seg_lo[i] = '0;
            end
            slots_searched = '0;
            errors = 0;
        endfunction

        // First usable entry in slot order whose segment bits equal the address's.
        function translation_t translate(logic [63:0] addr);
            translation_t res;
            int           span;
            logic [63:0]  mask;
            bit           usable;
            res = '0;
            span = (slots_searched > SLOTS) ? SLOTS : slots_searched;
            for (int n = 0; n < span; n++) begin
                usable = seg_hi[n][VALID_BIT];
                mask = '0;
                case (seg_size_t'(seg_hi[n][SIZE_LSB +: 2]))
                    SIZE_256MB: mask = MASK_256MB;
                    SIZE_1TB:   mask = MASK_1TB;
                    default:    usable = 1'b0;
                endcase
                if (usable && ((addr & mask) == (seg_hi[n] & mask))) begin
                    res.found       = 1'b1;
                    res.vsid        = {seg_hi[n][25:0], seg_lo[n][31:8]};
                    res.offset_mask = ~mask;
                    res.attributes  = seg_lo[n][7:0];
                    return res;
                end
            end
            return res;
        endfunction

        function void note_item(seg_item_t it);
            if (it.op == OP_WRITE) begin
                seg_hi[it.slot] = it.hi;
                seg_lo[it.slot] = it.lo;
                pending.push_back('0);
            end else begin
                pending.push_back(translate(it.addr));
            end
        endfunction

        function void check_result(logic found, logic [OUT_DATA_W-1:0] data);
            translation_t want;
            if (pending.size() == 0) begin
                $error("result item with no expectation waiting");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (found !== want.found) begin
                $error("found: expected %0h, got %0h", want.found, found);
                errors++;
            end
            if (data[49:0] !== want.vsid) begin
                $error("vsid: expected %h, got %h", want.vsid, data[49:0]);
                errors++;
            end
            if (data[113:50] !== want.offset_mask) begin
                $error("offset_mask: expected %h, got %h", want.offset_mask, data[113:50]);
                errors++;
            end
            if (data[121:114] !== want.attributes) begin
                $error("attributes: expected %h, got %h", want.attributes, data[121:114]);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CNT_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b1;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    seg_scoreboard sb = new();
    logic [63:0]   seg_pool [8];
    bit            tx_idle = 1'b1;
    bit            rx_idle = 1'b1;
    int            rdy_hold = 0;
    int            cycle_count = 0;

    segment_table_lookup u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_CAP) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Receiver stalls: ready is dropped and raised again at random while rx_idle is set, else held high.
    always @(posedge aclk) begin
        if (!rx_idle) begin
            m_tready <= 1'b1;
            rdy_hold <= 0;
        end else if (rdy_hold != 0) begin
            rdy_hold <= rdy_hold - 1;
        end else if (m_tready) begin
            m_tready <= 1'b0;
            rdy_hold <= $urandom_range(0, 10);
        end else begin
            m_tready <= 1'b1;
            rdy_hold <= $urandom_range(0, 29);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tuser, m_tdata);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic seg_item_t write_item(logic [5:0] slot, logic [63:0] hi, logic [31:0] lo);
        seg_item_t it;
        it.op   = OP_WRITE;
        it.slot = slot;
        it.hi   = hi;
        it.lo   = lo;
        it.addr = rand64();
        return it;
    endfunction

    function automatic seg_item_t lookup_item(logic [63:0] addr);
        seg_item_t it;
        it.op   = OP_LOOKUP;
        it.slot = 6'($urandom_range(0, SLOTS - 1));
        it.hi   = rand64();
        it.lo   = $urandom;
        it.addr = addr;
        return it;
    endfunction

    // Mostly a slot that the current count actually searches.
    function automatic logic [5:0] pick_slot();
        int span;
        span = (sb.slots_searched > SLOTS) ? SLOTS : sb.slots_searched;
        if (span > 0 && $urandom_range(0, 4) != 0) begin
            return 6'($urandom_range(0, span - 1));
        end
        return 6'($urandom_range(0, SLOTS - 1));
    endfunction

    function automatic seg_item_t random_item();
        seg_item_t   it;
        logic [63:0] base;
        int          r;
        int          flip;
        if ($urandom_range(0, 99) < 55) begin
            it = lookup_item(rand64());
            r = $urandom_range(0, 99);
            if (r < 70) begin
                // Aim at a stored entry, sometimes one bit off in the segment.
                base = sb.seg_hi[pick_slot()];
                it.addr[63:40] = base[63:40];
                if ($urandom_range(0, 1) == 1) begin
                    it.addr[39:28] = base[39:28];
                end
                if ($urandom_range(0, 9) == 0) begin
                    flip = $urandom_range(28, 63);
                    it.addr[flip] = ~it.addr[flip];
                end
            end else if (r < 85) begin
                it.addr[63:28] = seg_pool[$urandom_range(0, 7)][63:28];
            end
        end else begin
            it = write_item(pick_slot(), rand64(), $urandom);
            if ($urandom_range(0, 9) < 6) begin
                it.hi[63:28] = seg_pool[$urandom_range(0, 7)][63:28];
            end
            it.hi[VALID_BIT] = ($urandom_range(0, 99) < 85);
            r = $urandom_range(0, 9);
            if (r < 5) begin
                it.hi[SIZE_LSB +: 2] = SIZE_256MB;
            end else if (r < 8) begin
                it.hi[SIZE_LSB +: 2] = SIZE_1TB;
            end else begin
                it.hi[SIZE_LSB +: 2] = ($urandom_range(0, 1) == 1) ? SIZE_RES_A : SIZE_RES_B;
            end
        end
        return it;
    endfunction

    // Presents one item, with an optional gap first, and returns at the edge that takes it.
    task automatic send(seg_item_t it);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {2'b00, it.addr, it.lo, it.hi, it.slot};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(it);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic set_entries_in_use(logic [CNT_W-1:0] count);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.slots_searched = count;
    endtask

    initial begin
        logic [63:0] seg_x;
        logic [63:0] rnd;
        int          phase_count [NUM_PHASES];
        int          phase_items [NUM_PHASES];

        seg_x = 64'h1234_5678_9000_0000;
        phase_count = '{64, 127, 0, 1, $urandom_range(2, 63), 64, 32};
        phase_items = '{200, 150, 40, 40, 150, 200, 150};
        for (int i = 0; i < 4; i++) begin
            seg_pool[i] = rand64();
        end
        // The upper half shares its 1 TB segment bits with the lower half.
        for (int i = 4; i < 8; i++) begin
            rnd = rand64();
            seg_pool[i] = {seg_pool[i - 4][63:40], rnd[39:0]};
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Count still zero after reset: nothing can match.
        send(lookup_item(64'h0));
        send(write_item(6'd0, 64'hFFFF_FFFF_F9FF_FFFF, 32'hFFFF_FFFF));
        send(lookup_item(64'hFFFF_FFFF_FFFF_FFFF));
        drain();
        set_entries_in_use(7'd1);
        send(lookup_item(64'hFFFF_FFFF_F000_0000));
        send(lookup_item(64'hFFFF_FFFE_FFFF_FFFF));
        send(write_item(6'd1, 64'h0, 32'h0));
        // Two entries with reserved sizes, one of them in the same segment, ahead of a usable one in that segment.
        send(write_item(6'd2, seg_x | 64'h0C12_3456, $urandom));
        send(write_item(6'd3, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0001));
        send(write_item(6'd4, seg_x | 64'h08AB_CDEF, 32'h1357_9BDF));
        send(write_item(6'd5, 64'hABCD_EF12_3A45_6789, 32'h2468_ACE0));
        send(write_item(6'd63, 64'h0000_0000_0800_0000, 32'h0000_00A5));
        drain();
        set_entries_in_use(7'd64);
        send(lookup_item(seg_x | 64'h0FFF_FFFF));
        send(lookup_item(64'hABCD_EF77_7777_7777));
        send(lookup_item(64'h0000_0000_0FFF_FFFF));
        send(lookup_item(64'hFFFF_FFFF_FFFF_FFFF));
        send(lookup_item(64'h5555_5555_5555_5555));
        drain();
        // A count above the table size searches the whole table.
        set_entries_in_use(7'd127);
        send(lookup_item(64'h0));
        send(lookup_item(64'hAAAA_AAAA_AAAA_AAAA));
        drain();
        set_entries_in_use(7'd63);
        send(lookup_item(64'h0));
        send(lookup_item(64'hABCD_EF00_0000_0000));

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            set_entries_in_use(CNT_W'(phase_count[p]));
            tx_idle = (p != 2) && (p != NUM_PHASES - 1);
            rx_idle = tx_idle;
            repeat (phase_items[p]) send(random_item());
        end

        drain();
        repeat (SETTLE) @(posedge aclk);
        if (sb.pending.size() != 0) begin
            $error("%0d expected result items never arrived", sb.pending.size());
        end
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/stl_pkg.sv
sv/segment_table_lookup.sv
sv/stl_checker.sv
tb/sv/tb_segment_table_lookup.sv
